### src/acls_pkg.sv
// ----------------------------------------------------------------------------
// acls_pkg
// Shared types and constants for the accent color lightness shift block.
// ----------------------------------------------------------------------------
`default_nettype none

package acls_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_SHIFT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DARK_SHIFT  = 1'b1;

    // Item widths
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;

    // Luma weights and threshold for the light/dark decision
    localparam logic [13:0] LUMA_R   = 14'd2126;
    localparam logic [13:0] LUMA_G   = 14'd7152;
    localparam logic [13:0] LUMA_B   = 14'd722;
    localparam logic [21:0] LUMA_MID = 22'd1275000;

    // Doubled lightness full scale
    localparam logic [8:0] L2_FULL = 9'd510;

    // Pipeline depth: decode, lightness, multiply, numerator, four divider steps
    localparam int PIPE_DEPTH = 8;

    // Role of a channel within its colour
    typedef enum logic [1:0] {
        ROLE_MAX = 2'd0,
        ROLE_MIN = 2'd1,
        ROLE_MID = 2'd2
    } role_t;

    typedef logic [CHAN_W-1:0] chan_t;

endpackage

`default_nettype wire

### src/acls_stream_if.sv
// ----------------------------------------------------------------------------
// acls_in_if / acls_out_if
// Valid/ready channels carrying input colours and shifted results.
// ----------------------------------------------------------------------------
`default_nettype none

interface acls_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] color_in;

    modport source (output valid, output color_in, input ready);
    modport sink   (input valid, input color_in, output ready);
endinterface

interface acls_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] color_out;
    logic        was_light;

    modport source (output valid, output color_out, output was_light, input ready);
    modport sink   (input valid, input color_out, input was_light, output ready);
endinterface

`default_nettype wire

### src/accent_color_lightness_shift.sv
// ----------------------------------------------------------------------------
// accent_color_lightness_shift
// Shifts the HSL lightness of one colour per item, keeping hue and saturation.
// ----------------------------------------------------------------------------
// One colour is accepted every clock when the output side is not stalled.
// Each item passes through the pipeline in order: a decode stage (luma
// test, max/min), a lightness stage (clamped shift), a multiply stage, a
// numerator stage and a four-stage restoring divider that resolves two
// quotient bits per stage. Each stage holds its own item while stalled, so
// empty stages keep filling behind a waiting result.
// Configuration writes take effect for items accepted afterwards.
`default_nettype none

module accent_color_lightness_shift (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [acls_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [acls_pkg::CFG_DATA_W-1:0]  cfg_data,
    acls_in_if.sink                           src_ch,
    acls_out_if.source                        dst_ch
);
    import acls_pkg::*;

    // One quotient bit of the restoring divider
    function automatic logic [18:0] div_step(input logic [17:0] rem,
                                             input logic [8:0] dvs,
                                             input int k);
        logic [17:0] sub;
        begin
            sub = {9'd0, dvs} << k;
            if (rem >= sub)
                div_step = {1'b1, rem - sub};
            else
                div_step = {1'b0, rem};
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0] light_shift_reg;
    logic [8:0] dark_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_shift_reg <= '0;
            dark_shift_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LIGHT_SHIFT: light_shift_reg <= cfg_data;
                REG_DARK_SHIFT:  dark_shift_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage advance
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH:0]   adv;

    always_comb
    begin
        adv[PIPE_DEPTH] = dst_ch.ready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= src_ch.valid;
            for (int k = 1; k < PIPE_DEPTH; k++)
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign src_ch.ready = adv[0];

    // ------------------------------------------------------------------
    // Stage A: luma test, shift select, max and min
    // ------------------------------------------------------------------
    chan_t             in_ch [3];
    logic [21:0]       luma;
    logic              in_light;
    logic signed [9:0] in_shift;
    chan_t             in_mx;
    chan_t             in_mn;

    always_comb
    begin
        in_ch[0] = src_ch.color_in[7:0];
        in_ch[1] = src_ch.color_in[15:8];
        in_ch[2] = src_ch.color_in[23:16];
        luma = 22'(LUMA_R) * 22'(in_ch[0])
             + 22'(LUMA_G) * 22'(in_ch[1])
             + 22'(LUMA_B) * 22'(in_ch[2]);
        in_light = luma > LUMA_MID;
        if (in_light)
            in_shift = -$signed({light_shift_reg[8], light_shift_reg});
        else if (dark_shift_reg != '0)
            in_shift = $signed({dark_shift_reg[8], dark_shift_reg});
        else
            in_shift = $signed({light_shift_reg[8], light_shift_reg});
        in_mx = in_ch[0];
        in_mn = in_ch[0];
        for (int i = 1; i < 3; i++)
        begin
            if (in_ch[i] > in_mx) in_mx = in_ch[i];
            if (in_ch[i] < in_mn) in_mn = in_ch[i];
        end
    end

    chan_t             a_ch_reg [3];
    logic              a_light_reg;
    logic signed [9:0] a_shift_reg;
    chan_t             a_mx_reg;
    chan_t             a_mn_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_ch_reg    <= in_ch;
            a_light_reg <= in_light;
            a_shift_reg <= in_shift;
            a_mx_reg    <= in_mx;
            a_mn_reg    <= in_mn;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: doubled lightness, clamped shift, distances, roles
    // ------------------------------------------------------------------
    logic [8:0]         l2;
    logic signed [10:0] u2;
    logic signed [10:0] lo_lim;
    logic signed [10:0] hi_lim;
    logic signed [10:0] n_wide;
    logic [8:0]         n_val;
    logic [8:0]         d_wide;
    logic [8:0]         dn_wide;
    logic signed [8:0]  hd;
    role_t              role [3];

    always_comb
    begin
        l2     = {1'b0, a_mx_reg} + {1'b0, a_mn_reg};
        u2     = {a_shift_reg, 1'b0};
        lo_lim = -$signed({2'b00, l2});
        hi_lim = $signed({2'b00, L2_FULL}) - $signed({2'b00, l2});
        if (u2 < lo_lim) u2 = lo_lim;
        if (u2 > hi_lim) u2 = hi_lim;
        n_wide  = $signed({2'b00, l2}) + u2;
        n_val   = n_wide[8:0];
        d_wide  = (l2 > 9'd255) ? L2_FULL - l2 : l2;
        dn_wide = (n_val > 9'd255) ? L2_FULL - n_val : n_val;
        if (a_mx_reg == a_ch_reg[0])
            hd = $signed({1'b0, a_ch_reg[1]}) - $signed({1'b0, a_ch_reg[2]});
        else if (a_mx_reg == a_ch_reg[1])
            hd = $signed({1'b0, a_ch_reg[2]}) - $signed({1'b0, a_ch_reg[0]});
        else
            hd = $signed({1'b0, a_ch_reg[0]}) - $signed({1'b0, a_ch_reg[1]});
        for (int i = 0; i < 3; i++)
        begin
            if (a_ch_reg[i] == a_mx_reg)      role[i] = ROLE_MAX;
            else if (a_ch_reg[i] == a_mn_reg) role[i] = ROLE_MIN;
            else                              role[i] = ROLE_MID;
        end
    end

    logic [8:0] b_n_reg;
    chan_t      b_d_reg;
    chan_t      b_dn_reg;
    chan_t      b_c_reg;
    chan_t      b_ha_reg;
    role_t      b_role_reg [3];
    logic       b_grey_reg;
    logic       b_light_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            b_n_reg     <= n_val;
            b_d_reg     <= d_wide[7:0];
            b_dn_reg    <= dn_wide[7:0];
            b_c_reg     <= a_mx_reg - a_mn_reg;
            b_ha_reg    <= hd[8] ? 8'(-hd) : hd[7:0];
            b_role_reg  <= role;
            b_grey_reg  <= a_mx_reg == a_mn_reg;
            b_light_reg <= a_light_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: products
    // ------------------------------------------------------------------
    logic [16:0] c_base_reg;
    logic [15:0] c_p_reg;
    logic [15:0] c_h_reg;
    chan_t       c_d_reg;
    role_t       c_role_reg [3];
    logic        c_grey_reg;
    chan_t       c_gval_reg;
    logic        c_light_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            c_base_reg  <= b_n_reg * b_d_reg;
            c_p_reg     <= b_dn_reg * b_c_reg;
            c_h_reg     <= b_dn_reg * b_ha_reg;
            c_d_reg     <= b_d_reg;
            c_role_reg  <= b_role_reg;
            c_grey_reg  <= b_grey_reg;
            c_gval_reg  <= b_n_reg[8:1];
            c_light_reg <= b_light_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: numerators, rounding offset, saturation test
    // ------------------------------------------------------------------
    logic signed [19:0] num  [3];
    logic [17:0]        dvd  [3];
    logic [8:0]         dvs;
    logic [16:0]        sat_lim;

    always_comb
    begin
        dvs     = {c_d_reg, 1'b0};
        sat_lim = {dvs, 8'd0};
        for (int i = 0; i < 3; i++)
        begin
            num[i] = $signed({3'b000, c_base_reg}) - $signed({4'b0000, c_p_reg});
            if (c_role_reg[i] == ROLE_MAX)
                num[i] = $signed({3'b000, c_base_reg}) + $signed({4'b0000, c_p_reg});
            else if (c_role_reg[i] == ROLE_MID)
                num[i] = num[i] + $signed({3'b000, c_h_reg, 1'b0});
            if (num[i] < 0)
                num[i] = '0;
            dvd[i] = num[i][17:0] + {10'd0, c_d_reg};
        end
    end

    // Divider stage registers; index 0 is the numerator stage output
    logic [17:0] dv_rem_reg   [5][3];
    logic [7:0]  dv_q_reg     [5][3];
    logic        dv_sat_reg   [5][3];
    logic [8:0]  dv_dvs_reg   [5];
    logic        dv_grey_reg  [5];
    chan_t       dv_gval_reg  [5];
    logic        dv_light_reg [5];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= dvd[i];
                dv_q_reg[0][i]   <= '0;
                dv_sat_reg[0][i] <= {1'b0, dvd[i]} >= {2'b00, sat_lim};
            end
            dv_dvs_reg[0]   <= dvs;
            dv_grey_reg[0]  <= c_grey_reg;
            dv_gval_reg[0]  <= c_gval_reg;
            dv_light_reg[0] <= c_light_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: two quotient bits per stage, high bits first
    // ------------------------------------------------------------------
    for (genvar j = 1; j < 5; j++)
    begin : g_div
        logic [18:0] step_hi [3];
        logic [18:0] step_lo [3];

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                step_hi[i] = div_step(dv_rem_reg[j-1][i], dv_dvs_reg[j-1], 9 - 2 * j);
                step_lo[i] = div_step(step_hi[i][17:0], dv_dvs_reg[j-1], 8 - 2 * j);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[3+j])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_rem_reg[j][i] <= step_lo[i][17:0];
                    dv_q_reg[j][i]   <= dv_q_reg[j-1][i]
                                        | (8'(step_hi[i][18]) << (9 - 2 * j))
                                        | (8'(step_lo[i][18]) << (8 - 2 * j));
                    dv_sat_reg[j][i] <= dv_sat_reg[j-1][i];
                end
                dv_dvs_reg[j]   <= dv_dvs_reg[j-1];
                dv_grey_reg[j]  <= dv_grey_reg[j-1];
                dv_gval_reg[j]  <= dv_gval_reg[j-1];
                dv_light_reg[j] <= dv_light_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: pick grey, saturated or divided channel
    // ------------------------------------------------------------------
    chan_t out_ch [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_grey_reg[4])
                out_ch[i] = dv_gval_reg[4];
            else if (dv_sat_reg[4][i])
                out_ch[i] = 8'd255;
            else
                out_ch[i] = dv_q_reg[4][i];
        end
    end

    assign dst_ch.valid     = vld_reg[PIPE_DEPTH-1];
    assign dst_ch.color_out = {out_ch[2], out_ch[1], out_ch[0]};
    assign dst_ch.was_light = dv_light_reg[4];

endmodule

`default_nettype wire

### src/acls_checker.sv
// ----------------------------------------------------------------------------
// acls_checker
// Port-level checks on the lightness shift pipeline and its flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module acls_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] color_out,
    input wire logic        was_light
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(color_out) && $stable(was_light))
        else $error("stalled result changed");

    // Drain keeps the input open
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    // Empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output stage");

    // No result appears right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown after reset");

endmodule

bind accent_color_lightness_shift acls_checker u_acls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (src_ch.ready),
    .out_valid (dst_ch.valid),
    .out_ready (dst_ch.ready),
    .color_out (dst_ch.color_out),
    .was_light (dst_ch.was_light)
);

`default_nettype wire
